// ===== rtl/lph_pkg.sv =====
// Types and constants shared by the linear probe hash table.
package lph_pkg;

    localparam logic [63:0] GOLDEN_MULT = 64'd11400714819323198485;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISS     = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_ZERO_KEY = 2'd3;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_TAKE   = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [63:0] key;
        logic [31:0] buf_handle;
        logic [31:0] path_handle;
        logic [31:0] length;
        logic [2:0]  kind;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_buf;
        logic [31:0] found_path;
        logic [31:0] found_length;
        logic [2:0]  found_kind;
        logic [6:0]  entry_total;
    } t_out_word;

    // slot contents: key, buf, path, length, kind
    typedef struct packed {
        logic [63:0] key;
        logic [31:0] buf_handle;
        logic [31:0] path_handle;
        logic [31:0] length;
        logic [2:0]  kind;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH_LO,
        S_HASH_HI,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_WALK_RD,
        S_WALK_CHK,
        S_PLACE_RD,
        S_PLACE_CHK,
        S_DONE
    } t_state;

endpackage

// ===== rtl/lph_ram.sv =====
// Generic single-port synchronous RAM with registered read.
module lph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/linear_probe_hash_table.sv =====
// Top level of the linear probe hash table.
// One command at a time: start is taken while busy is low, and one result
// word appears on o_result for a single cycle under o_done; the receiver has
// no way to hold it off. The slot store is one single-port RAM read one slot
// at a time: a command hashes its key in S_HASH_LO and S_HASH_HI, then reads
// and checks one slot after another. A take that hits clears its slot, then
// reads each later entry of the cluster, clears it, rehashes it and places it
// again. Zero keys and full inserts skip the hash and the probe. The next
// command can be taken at the edge that takes the result. After reset the
// store is cleared one slot a cycle, with busy high; configuration writes are
// taken at all times outside reset.
module linear_probe_hash_table #(
    parameter int TABLE_DEPTH = 64,
    parameter int HASH_BITS   = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  lph_pkg::t_in_word     i_cmd,
    output logic                  o_done,
    output lph_pkg::t_out_word    o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [5:0]            i_cfg_data
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    lph_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_addr, n_addr;
    logic [AW-1:0]   r_walk, n_walk;
    logic [CW-1:0]   r_steps, n_steps;
    logic [CW-1:0]   r_wsteps, n_wsteps;
    logic [CW-1:0]   r_count, n_count;
    logic [5:0]      r_limit;
    lph_pkg::t_in_word r_cmd, n_cmd;
    lph_pkg::t_slot  r_hold, n_hold;
    lph_pkg::t_out_word r_res, n_res;
    logic            r_done, n_done;
    logic            r_walking, n_walking;
    logic [63:0]     r_prod_lo, n_prod_lo;
    logic [31:0]     r_prod_hi, n_prod_hi;
    logic [AW-1:0]   n_home;

    logic            ram_we;
    logic [AW-1:0]   ram_addr;
    lph_pkg::t_slot  ram_wdata, ram_rdata;

    lph_ram #(.WIDTH(lph_pkg::SLOT_W), .DEPTH(TABLE_DEPTH)) u_slots (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    assign o_cfg_ready = 1'b1;
    assign busy        = (r_state != lph_pkg::S_IDLE);
    assign o_done      = r_done;
    assign o_result    = r_res;

    // key * golden mod 2^64: partial products registered in the first step,
    // the high cross terms added in the second step
    logic [63:0] p_lo;
    logic [31:0] p_hi;
    logic [63:0] hash;
    assign p_lo = {32'd0, r_cmd.key[31:0]} * {32'd0, lph_pkg::GOLDEN_MULT[31:0]};
    assign p_hi = 32'(r_cmd.key[63:32] * lph_pkg::GOLDEN_MULT[31:0])
                + 32'(r_cmd.key[31:0] * lph_pkg::GOLDEN_MULT[63:32]);
    assign hash = {r_prod_lo[63:32] + r_prod_hi, r_prod_lo[31:0]};
    assign n_home = AW'(hash[63 -: HASH_BITS] % TABLE_DEPTH);

    logic [AW-1:0] addr_inc, walk_inc;
    assign addr_inc = (r_addr == AW'(TABLE_DEPTH - 1)) ? '0 : r_addr + 1'b1;
    assign walk_inc = (r_walk == AW'(TABLE_DEPTH - 1)) ? '0 : r_walk + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lph_pkg::S_CLEAR;
            r_addr  <= '0;
            r_count <= '0;
            r_limit <= 6'd39;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_count <= n_count;
            r_done  <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
        end
        r_walk    <= n_walk;
        r_steps   <= n_steps;
        r_wsteps  <= n_wsteps;
        r_cmd     <= n_cmd;
        r_hold    <= n_hold;
        r_res     <= n_res;
        r_walking <= n_walking;
        r_prod_lo <= n_prod_lo;
        r_prod_hi <= n_prod_hi;
    end

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_walk    = r_walk;
        n_steps   = r_steps;
        n_wsteps  = r_wsteps;
        n_count   = r_count;
        n_cmd     = r_cmd;
        n_hold    = r_hold;
        n_res     = r_res;
        n_walking = r_walking;
        n_done    = 1'b0;
        n_prod_lo = p_lo;
        n_prod_hi = p_hi;
        ram_we    = 1'b0;
        ram_addr  = r_addr;
        ram_wdata = '0;
        unique case (r_state)
            lph_pkg::S_CLEAR: begin
                ram_we = 1'b1;
                n_addr = addr_inc;
                if (r_addr == AW'(TABLE_DEPTH - 1)) begin
                    n_state = lph_pkg::S_IDLE;
                end
            end
            lph_pkg::S_IDLE: begin
                if (start) begin
                    n_cmd = i_cmd;
                    n_walking = 1'b0;
                    n_res = '0;
                    n_res.entry_total = 7'(r_count);
                    if (i_cmd.key == '0) begin
                        n_res.status = lph_pkg::ST_ZERO_KEY;
                        n_state = lph_pkg::S_DONE;
                    end else if (i_cmd.mode == lph_pkg::MODE_INSERT &&
                                 (r_count >= CW'(r_limit) ||
                                  r_count >= CW'(TABLE_DEPTH - 1))) begin
                        n_res.status = lph_pkg::ST_FULL;
                        n_state = lph_pkg::S_DONE;
                    end else begin
                        n_hold = {i_cmd.key, i_cmd.buf_handle, i_cmd.path_handle,
                                  i_cmd.length, i_cmd.kind};
                        n_state = lph_pkg::S_HASH_LO;
                    end
                end
            end
            lph_pkg::S_HASH_LO: begin
                n_state = lph_pkg::S_HASH_HI;
            end
            lph_pkg::S_HASH_HI: begin
                n_addr  = n_home;
                n_steps = '0;
                n_state = (r_cmd.mode == lph_pkg::MODE_TAKE && !r_walking)
                        ? lph_pkg::S_PROBE_RD : lph_pkg::S_PLACE_RD;
            end
            lph_pkg::S_PROBE_RD: begin
                n_state = lph_pkg::S_PROBE_CHK;
            end
            lph_pkg::S_PROBE_CHK: begin
                if (ram_rdata.key == r_cmd.key) begin
                    n_res.status       = lph_pkg::ST_OK;
                    n_res.found_buf    = ram_rdata.buf_handle;
                    n_res.found_path   = ram_rdata.path_handle;
                    n_res.found_length = ram_rdata.length;
                    n_res.found_kind   = ram_rdata.kind;
                    ram_we    = 1'b1;
                    n_count   = r_count - 1'b1;
                    n_walk    = addr_inc;
                    n_wsteps  = '0;
                    n_addr    = addr_inc;
                    n_walking = 1'b1;
                    n_state   = lph_pkg::S_WALK_RD;
                end else if (ram_rdata.key == '0 ||
                             r_steps == CW'(TABLE_DEPTH - 1)) begin
                    n_res.status = lph_pkg::ST_MISS;
                    n_state = lph_pkg::S_DONE;
                end else begin
                    n_steps = r_steps + 1'b1;
                    n_addr  = addr_inc;
                    n_state = lph_pkg::S_PROBE_RD;
                end
            end
            lph_pkg::S_WALK_RD: begin
                ram_addr = r_walk;
                n_state  = lph_pkg::S_WALK_CHK;
            end
            lph_pkg::S_WALK_CHK: begin
                ram_addr = r_walk;
                if (ram_rdata.key == '0 || r_wsteps == CW'(TABLE_DEPTH)) begin
                    n_state = lph_pkg::S_DONE;
                end else begin
                    n_hold  = ram_rdata;
                    ram_we  = 1'b1;
                    n_count = r_count - 1'b1;
                    n_cmd.key = ram_rdata.key;
                    n_state = lph_pkg::S_HASH_LO;
                end
            end
            lph_pkg::S_PLACE_RD: begin
                n_state = lph_pkg::S_PLACE_CHK;
            end
            lph_pkg::S_PLACE_CHK: begin
                if (ram_rdata.key == '0) begin
                    ram_we    = 1'b1;
                    ram_wdata = r_hold;
                    n_count   = r_count + 1'b1;
                    if (r_walking) begin
                        n_walk   = walk_inc;
                        n_wsteps = r_wsteps + 1'b1;
                        n_state  = lph_pkg::S_WALK_RD;
                    end else begin
                        n_state = lph_pkg::S_DONE;
                    end
                end else begin
                    n_addr  = addr_inc;
                    n_state = lph_pkg::S_PLACE_RD;
                end
            end
            lph_pkg::S_DONE: begin
                n_res.entry_total = 7'(r_count);
                n_done  = 1'b1;
                n_state = lph_pkg::S_IDLE;
            end
            default: begin
                n_state = lph_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH - 1))
        else $error("entry count out of range");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result while busy");
    a_ok_take_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lph_pkg::S_PROBE_CHK && ram_rdata.key == r_cmd.key)
        |=> r_count == $past(r_count) - 1'b1)
        else $error("take did not decrement count");
`endif
endmodule

// ===== test/linear_probe_hash_table_tb.sv =====
// Self-checking testbench for the linear probe hash table: random and directed commands.
module linear_probe_hash_table_tb;

    localparam int DEPTH     = 64;
    localparam int HBITS     = 20;
    localparam int WDOG_MAX  = 100000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    lph_pkg::t_in_word   i_cmd = '0;
    logic       o_done;
    lph_pkg::t_out_word  o_result;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [5:0] i_cfg_data = '0;

    linear_probe_hash_table u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    lph_pkg::t_slot tbl [DEPTH];
    int unsigned used_cnt;
    int unsigned fill_lim;

    lph_pkg::t_in_word  cmd_q [$];
    lph_pkg::t_out_word result_q [$];
    bit        errors;
    bit        quiet;
    int        wdog;
    logic [63:0] live_keys [$];

    function automatic int unsigned home_slot(logic [63:0] key);
        logic [63:0] h;
        h = key * lph_pkg::GOLDEN_MULT;
        return int'(h[63 -: HBITS]) % DEPTH;
    endfunction

    function automatic void put_slot(lph_pkg::t_slot e);
        int unsigned s;
        s = home_slot(e.key);
        for (int n = 0; n < DEPTH && tbl[s].key != 0; n++) s = (s + 1) % DEPTH;
        if (tbl[s].key != 0) return;
        tbl[s] = e;
        used_cnt++;
    endfunction

    function automatic lph_pkg::t_out_word apply_cmd(lph_pkg::t_in_word c);
        lph_pkg::t_out_word r;
        lph_pkg::t_slot     e;
        int unsigned s, t;
        bit hit;
        r = '0;
        if (c.key == 0) begin
            r.status = lph_pkg::ST_ZERO_KEY;
        end else if (c.mode == lph_pkg::MODE_INSERT) begin
            if (used_cnt >= fill_lim || used_cnt >= DEPTH - 1) begin
                r.status = lph_pkg::ST_FULL;
            end else begin
                e.key = c.key; e.buf_handle = c.buf_handle; e.path_handle = c.path_handle;
                e.length = c.length; e.kind = c.kind;
                put_slot(e);
            end
        end else begin
            s = home_slot(c.key);
            hit = 0;
            r.status = lph_pkg::ST_MISS;
            for (int n = 0; n < DEPTH; n++) begin
                if (tbl[s].key == c.key) begin
                    hit = 1;
                    break;
                end
                if (tbl[s].key == 0) break;
                s = (s + 1) % DEPTH;
            end
            if (hit) begin
                r.status       = lph_pkg::ST_OK;
                r.found_buf    = tbl[s].buf_handle;
                r.found_path   = tbl[s].path_handle;
                r.found_length = tbl[s].length;
                r.found_kind   = tbl[s].kind;
                tbl[s] = '0;
                used_cnt--;
                t = (s + 1) % DEPTH;
                for (int n = 0; n < DEPTH && tbl[t].key != 0; n++) begin
                    e = tbl[t];
                    tbl[t] = '0;
                    used_cnt--;
                    put_slot(e);
                    t = (t + 1) % DEPTH;
                end
            end
        end
        r.entry_total = used_cnt[6:0];
        return r;
    endfunction

    // busy as seen at the last rising edge, with the command that edge accepted
    logic busy_s = 1'b1;
    always @(posedge i_clk) begin
        busy_s <= busy;
        if (i_rst_n && start && !busy) begin
            result_q.push_back(apply_cmd(i_cmd));
        end
    end

    // driver
    int gap_in;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy_s) begin
                void'(cmd_q.pop_front());
            end
            if (gap_in > 0) begin
                gap_in <= gap_in - 1;
                start  <= 1'b0;
            end else if (cmd_q.size() != 0) begin
                if (!quiet && $urandom_range(0, 7) == 0) begin
                    gap_in <= $urandom_range(1, 6);
                    start  <= 1'b0;
                end else begin
                    start <= 1'b1;
                    i_cmd <= cmd_q[0];
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (result_q.size() == 0) begin
                $display("%0t: unexpected word %h", $time, o_result);
                errors = 1;
            end else begin
                if (o_result !== result_q[0]) begin
                    $display("%0t: mismatch expected %h actual %h", $time, result_q[0], o_result);
                    errors = 1;
                end
                void'(result_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) wdog <= 0;
        else wdog <= wdog + 1;
        if (wdog >= WDOG_MAX) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic lph_pkg::t_in_word rand_word(logic mode, logic [63:0] key);
        lph_pkg::t_in_word c;
        c.mode = mode;
        c.key = key;
        c.buf_handle = $urandom;
        c.path_handle = $urandom;
        c.length = $urandom;
        c.kind = 3'($urandom_range(0, 7));
        return c;
    endfunction

    function automatic logic [63:0] rand_key();
        return {$urandom, $urandom} | 64'd1;
    endfunction

    task automatic drain();
        wait (cmd_q.size() == 0);
        @(posedge i_clk);
        while (start || result_q.size() != 0 || busy) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_limit(int unsigned v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v[5:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        fill_lim = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random(int cnt);
        lph_pkg::t_in_word c;
        logic [63:0] k;
        int idx;
        for (int i = 0; i < cnt; i++) begin
            case ($urandom_range(0, 9))
                0: c = rand_word(1'($urandom_range(0, 1)), 64'd0);
                1, 2, 3: begin
                    k = rand_key();
                    c = rand_word(lph_pkg::MODE_INSERT, k);
                    live_keys.push_back(k);
                end
                4: c = rand_word(lph_pkg::MODE_TAKE, rand_key());
                5: begin
                    if (live_keys.size() != 0) k = live_keys[$urandom_range(0, live_keys.size() - 1)];
                    else k = rand_key();
                    c = rand_word(lph_pkg::MODE_INSERT, k);
                end
                default: begin
                    if (live_keys.size() != 0) begin
                        idx = $urandom_range(0, live_keys.size() - 1);
                        k = live_keys[idx];
                        live_keys.delete(idx);
                    end else k = rand_key();
                    c = rand_word(lph_pkg::MODE_TAKE, k);
                end
            endcase
            cmd_q.push_back(c);
        end
    endtask

    initial begin
        lph_pkg::t_in_word c;
        for (int i = 0; i < DEPTH; i++) tbl[i] = '0;
        used_cnt = 0;
        fill_lim = 39;
        gap_in = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero keys, extremes, duplicates, miss
        cmd_q.push_back(rand_word(lph_pkg::MODE_INSERT, 64'd0));
        cmd_q.push_back(rand_word(lph_pkg::MODE_TAKE, 64'd0));
        c = '0; c.key = 64'hFFFF_FFFF_FFFF_FFFF;
        c.buf_handle = '1; c.path_handle = '1; c.length = '1; c.kind = 3'd7;
        cmd_q.push_back(c);
        c = '0; c.key = 64'd1;
        cmd_q.push_back(c);
        cmd_q.push_back(rand_word(lph_pkg::MODE_INSERT, 64'd1));
        cmd_q.push_back(rand_word(lph_pkg::MODE_TAKE, 64'd1));
        cmd_q.push_back(rand_word(lph_pkg::MODE_TAKE, 64'd1));
        cmd_q.push_back(rand_word(lph_pkg::MODE_TAKE, 64'd1));
        cmd_q.push_back(rand_word(lph_pkg::MODE_TAKE, 64'hFFFF_FFFF_FFFF_FFFF));
        cmd_q.push_back(rand_word(lph_pkg::MODE_TAKE, 64'h1234_5678_9ABC_DEF1));
        drain();

        set_limit(1);
        cmd_q.push_back(rand_word(lph_pkg::MODE_INSERT, 64'd5));
        cmd_q.push_back(rand_word(lph_pkg::MODE_INSERT, 64'd6));
        cmd_q.push_back(rand_word(lph_pkg::MODE_TAKE, 64'd5));
        drain();

        // fill to the hard limit of one free slot
        set_limit(63);
        for (int i = 0; i < 64; i++) cmd_q.push_back(rand_word(lph_pkg::MODE_INSERT, rand_key()));
        for (int i = 0; i < 6; i++) cmd_q.push_back(rand_word(lph_pkg::MODE_TAKE, rand_key()));
        drain();
        // empty the table again by taking every stored key
        for (int i = 0; i < DEPTH; i++)
            if (tbl[i].key != 0) cmd_q.push_back(rand_word(lph_pkg::MODE_TAKE, tbl[i].key));
        drain();

        set_limit(8);
        run_random(100);
        drain();
        set_limit(39);
        run_random(150);
        drain();
        set_limit(50);
        quiet = 1;
        run_random(60);
        drain();

        if (!errors) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/lph_pkg.sv
rtl/lph_ram.sv
rtl/linear_probe_hash_table.sv
test/linear_probe_hash_table_tb.sv
